### rtl/core/fqsmr_pkg.sv
// Package for the FIFO queue with sum, max and reverse: types, codes, defaults.
`timescale 1ns / 1ps

package fqsmr_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned VALUE_W         = 32;
	localparam int unsigned SUM_W           = 36;
	localparam int unsigned COUNT_OUT_W     = 5;

	typedef enum logic [1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_POP     = 2'd1,
		FUNC_REVERSE = 2'd2,
		FUNC_QUERY   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_WAIT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		func_t                     func;
		logic signed [VALUE_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] popped_value;
		status_t                   status;
		logic [COUNT_OUT_W-1:0]    entry_count;
		logic signed [SUM_W-1:0]   total_sum;
		logic signed [VALUE_W-1:0] largest_value;
		logic                      is_empty;
	} result_t;

endpackage

### rtl/core/fifo_queue_sum_max_reverse.sv
// Top level: bounded FIFO of signed words with running sum, max scan and reverse.
// Operation: the word is executed, a successful pop reads its value from the store, then
//   every stored entry is scanned for the max, and done is raised with the result.
// One word in flight: a new start is taken only once busy has dropped after done;
//   the wait grows with the max scan (one store read per entry); receiver cannot stall.
// Reset: arst_n clears pointers, count, direction and sum; the store is not cleared.
`timescale 1ns / 1ps

module fifo_queue_sum_max_reverse #(
	parameter int unsigned QUEUE_DEPTH = fqsmr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fqsmr_pkg::cmd_t    cmd,
	output logic               done,
	output fqsmr_pkg::result_t result
);

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// value store port signals
	logic                                 ram_we;
	logic [IW-1:0]                        ram_waddr;
	logic signed [fqsmr_pkg::VALUE_W-1:0] ram_wdata;
	logic                                 ram_re;
	logic [IW-1:0]                        ram_raddr;
	logic signed [fqsmr_pkg::VALUE_W-1:0] ram_rdata;

	// Sequencer: executes the word's operation against the ring (front slot plus
	// direction bit), then walks every stored entry in logical order to find the max.
	fqsmr_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IW         (IW),
		.CW         (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// Value store; a push write and later scan reads never hit in the same cycle.
	fqsmr_ram #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IW         (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

### rtl/core/fqsmr_ram.sv
// Value store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module fqsmr_ram #(
	parameter int unsigned QUEUE_DEPTH = fqsmr_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned IW          = $clog2(QUEUE_DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [IW-1:0]                        waddr,
	input  logic signed [fqsmr_pkg::VALUE_W-1:0] wdata,
	input  logic                                 re,
	input  logic [IW-1:0]                        raddr,
	output logic signed [fqsmr_pkg::VALUE_W-1:0] rdata
);

	logic signed [fqsmr_pkg::VALUE_W-1:0] mem_q [QUEUE_DEPTH];
	logic signed [fqsmr_pkg::VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/fqsmr_ctrl.sv
// Sequencer: ring pointers, count, running sum, max scan over the value store.
`timescale 1ns / 1ps

module fqsmr_ctrl #(
	parameter int unsigned QUEUE_DEPTH = fqsmr_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned IW          = $clog2(QUEUE_DEPTH),
	parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  fqsmr_pkg::cmd_t                      cmd,
	output logic                                 done,
	output fqsmr_pkg::result_t                   result,
	output logic                                 ram_we,
	output logic [IW-1:0]                        ram_waddr,
	output logic signed [fqsmr_pkg::VALUE_W-1:0] ram_wdata,
	output logic                                 ram_re,
	output logic [IW-1:0]                        ram_raddr,
	input  logic signed [fqsmr_pkg::VALUE_W-1:0] ram_rdata
);

	localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
	localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

	fqsmr_pkg::state_t state_q, state_d;

	fqsmr_pkg::cmd_t                      cmd_q;
	logic [IW-1:0]                        front_q;
	logic [CW-1:0]                        count_q;
	logic                                 rev_q;
	logic signed [fqsmr_pkg::SUM_W-1:0]   sum_q;
	logic signed [fqsmr_pkg::VALUE_W-1:0] popped_q;
	fqsmr_pkg::status_t                   status_q;
	logic signed [fqsmr_pkg::VALUE_W-1:0] best_q;
	logic [IW-1:0]                        scan_ptr_q;
	logic [CW-1:0]                        scan_idx_q;
	logic                                 rd_vld_s1;
	logic                                 first_s1;

	logic                                 is_full;
	logic                                 is_empty;
	logic                                 scan_issue;
	logic [IW-1:0]                        back_slot;
	logic [IW-1:0]                        tail_slot;
	logic [CW+fqsmr_pkg::COUNT_OUT_W-1:0] count_x;

	// next slot along the logical order
	function automatic logic [IW-1:0] step_slot(input logic [IW-1:0] p, input logic rev);
		logic [IW-1:0] r;
		if (rev) begin
			r = (p == '0) ? LAST_SLOT : p - IW'(1);
		end else begin
			r = (p == LAST_SLOT) ? '0 : p + IW'(1);
		end
		return r;
	endfunction

	// physical slot of logical position k
	function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] f, input logic [IW-1:0] k,
			input logic rev);
		logic [IW:0] s;
		if (rev) begin
			s = (k > f) ? ({1'b0, f} + DEPTH_X - {1'b0, k}) : ({1'b0, f} - {1'b0, k});
		end else begin
			s = {1'b0, f} + {1'b0, k};
			if (s >= DEPTH_X) begin
				s = s - DEPTH_X;
			end
		end
		return s[IW-1:0];
	endfunction

	assign is_full    = (count_q >= FULL_CNT);
	assign is_empty   = (count_q == '0);
	assign scan_issue = (state_q == fqsmr_pkg::ST_SCAN) && (scan_idx_q != count_q);
	// push lands at position count (only used when not full, so it fits)
	assign back_slot  = slot_at(front_q, IW'(count_q), rev_q);
	// last stored entry, new front on reverse
	assign tail_slot  = slot_at(front_q, IW'(count_q - CW'(1)), rev_q);

	assign ram_we    = (state_q == fqsmr_pkg::ST_EXEC) && (cmd_q.func == fqsmr_pkg::FUNC_PUSH)
			&& !is_full;
	assign ram_waddr = back_slot;
	assign ram_wdata = cmd_q.push_value;
	assign ram_re    = scan_issue || ((state_q == fqsmr_pkg::ST_EXEC)
			&& (cmd_q.func == fqsmr_pkg::FUNC_POP) && !is_empty);
	assign ram_raddr = (state_q == fqsmr_pkg::ST_SCAN) ? scan_ptr_q : front_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqsmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			fqsmr_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = fqsmr_pkg::ST_EXEC;
				end
			end
			fqsmr_pkg::ST_EXEC: begin
				if (cmd_q.func == fqsmr_pkg::FUNC_POP && !is_empty) begin
					state_d = fqsmr_pkg::ST_POP_WAIT;
				end else begin
					state_d = fqsmr_pkg::ST_SCAN;
				end
			end
			fqsmr_pkg::ST_POP_WAIT: begin
				state_d = fqsmr_pkg::ST_SCAN;
			end
			fqsmr_pkg::ST_SCAN: begin
				if (!scan_issue) begin
					state_d = fqsmr_pkg::ST_DONE;
				end
			end
			fqsmr_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = fqsmr_pkg::ST_IDLE;
			end
			default: begin
				state_d = fqsmr_pkg::ST_IDLE;
			end
		endcase
	end

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			rev_q      <= 1'b0;
			sum_q      <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (state_q == fqsmr_pkg::ST_EXEC) begin
				scan_idx_q <= '0;
				unique case (cmd_q.func)
					fqsmr_pkg::FUNC_PUSH: begin
						if (!is_full) begin
							count_q <= count_q + CW'(1);
							sum_q   <= sum_q + fqsmr_pkg::SUM_W'(cmd_q.push_value);
						end
					end
					fqsmr_pkg::FUNC_REVERSE: begin
						if (!is_empty) begin
							front_q <= tail_slot;
							rev_q   <= ~rev_q;
						end
					end
					fqsmr_pkg::FUNC_POP,
					fqsmr_pkg::FUNC_QUERY: begin
					end
					default: begin
					end
				endcase
			end else if (state_q == fqsmr_pkg::ST_POP_WAIT) begin
				sum_q   <= sum_q - fqsmr_pkg::SUM_W'(ram_rdata);
				front_q <= step_slot(front_q, rev_q);
				count_q <= count_q - CW'(1);
			end else if (scan_issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
		end
	end

	// per-item result and scan datapath
	always_ff @(posedge clk) begin
		if (state_q == fqsmr_pkg::ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		unique case (state_q)
			fqsmr_pkg::ST_EXEC: begin
				popped_q <= '0;
				best_q   <= '0;
				if (cmd_q.func == fqsmr_pkg::FUNC_PUSH && is_full) begin
					status_q <= fqsmr_pkg::STAT_FULL;
				end else if ((cmd_q.func == fqsmr_pkg::FUNC_POP
						|| cmd_q.func == fqsmr_pkg::FUNC_REVERSE) && is_empty) begin
					status_q <= fqsmr_pkg::STAT_EMPTY;
				end else begin
					status_q <= fqsmr_pkg::STAT_OK;
				end
				if (cmd_q.func == fqsmr_pkg::FUNC_REVERSE && !is_empty) begin
					scan_ptr_q <= tail_slot;
				end else begin
					scan_ptr_q <= front_q;
				end
			end
			fqsmr_pkg::ST_POP_WAIT: begin
				popped_q   <= ram_rdata;
				scan_ptr_q <= step_slot(front_q, rev_q);
			end
			fqsmr_pkg::ST_SCAN: begin
				if (scan_issue) begin
					scan_ptr_q <= step_slot(scan_ptr_q, rev_q);
				end
			end
			fqsmr_pkg::ST_IDLE,
			fqsmr_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
		first_s1 <= (scan_idx_q == '0);
		if (rd_vld_s1 && (first_s1 || ram_rdata > best_q)) begin
			best_q <= ram_rdata;
		end
	end

	assign count_x = {{fqsmr_pkg::COUNT_OUT_W{1'b0}}, count_q};

	assign result.popped_value  = popped_q;
	assign result.status        = status_q;
	assign result.entry_count   = count_x[fqsmr_pkg::COUNT_OUT_W-1:0];
	assign result.total_sum     = sum_q;
	assign result.largest_value = best_q;
	assign result.is_empty      = is_empty;

endmodule

### rtl/core/fqsmr_checker.sv
// Port-level checker for the FIFO queue, bound to the top level.
`timescale 1ns / 1ps

module fqsmr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input fqsmr_pkg::result_t result
);

	// an accepted word makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// results appear only while working, and the block frees up right after
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("done outside a busy period");

	// empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.entry_count == '0)))
		else $error("is_empty disagrees with entry_count");

	// an empty queue reports zero sum and zero max
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_empty |-> (result.total_sum == '0) && (result.largest_value == '0))
		else $error("empty queue with nonzero sum or max");

	// a non-ok status leaves nothing popped
	a_fail_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != fqsmr_pkg::STAT_OK) |-> (result.popped_value == '0))
		else $error("popped value on failed operation");

endmodule

bind fifo_queue_sum_max_reverse fqsmr_checker u_fqsmr_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

### bench/tb_fifo_queue_sum_max_reverse.sv
// Testbench for the bounded FIFO with running sum, max scan and order reversal.
`timescale 1ns / 1ps

module tb_fifo_queue_sum_max_reverse;
	import fqsmr_pkg::*;

	localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
	localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
	localparam int unsigned DRAIN_CYCLES = DEPTH + 24;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	fifo_queue_sum_max_reverse dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Shadow copy of the queue: ring of values, front slot, count, direction, sum.
	logic signed [VALUE_W-1:0] ring_vals [DEPTH];
	int unsigned               ring_front;
	int unsigned               ring_count;
	logic                      ring_rev;
	logic signed [SUM_W-1:0]   ring_sum;

	result_t     expected_words [$];
	int unsigned mismatch_count;
	int unsigned idle_pct;

	// Physical slot of logical position k (0 = front), following the direction bit.
	function automatic int unsigned ring_slot(input int unsigned k);
		if (ring_rev)
			return (ring_front + DEPTH - (k % DEPTH)) % DEPTH;
		return (ring_front + k) % DEPTH;
	endfunction

	// Applies one command to the shadow queue and returns the word the block owes.
	task automatic apply_queue_op(input cmd_t c, output result_t r);
		logic signed [VALUE_W-1:0] best;
		logic signed [VALUE_W-1:0] v;
		best = '0;
		r = '0;
		r.status = STAT_OK;
		case (c.func)
			FUNC_PUSH: begin
				if (ring_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					ring_vals[ring_slot(ring_count)] = c.push_value;
					ring_count++;
					ring_sum = ring_sum + c.push_value;
				end
			end
			FUNC_POP: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.popped_value = ring_vals[ring_slot(0)];
					ring_sum = ring_sum - r.popped_value;
					ring_front = ring_slot(1);
					ring_count--;
				end
			end
			FUNC_REVERSE: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					// new front is the old back; no data moves
					ring_front = ring_slot(ring_count - 1);
					ring_rev = ~ring_rev;
				end
			end
			default: ;
		endcase
		for (int unsigned i = 0; i < ring_count; i++) begin
			v = ring_vals[ring_slot(i)];
			if (i == 0 || v > best)
				best = v;
		end
		r.entry_count   = ring_count[COUNT_OUT_W-1:0];
		r.total_sum     = ring_sum;
		r.largest_value = best;
		r.is_empty      = (ring_count == 0);
	endtask

	// Sends one word: holds start until the block takes it, then maybe idles.
	// start is lowered only when a gap follows, so it never toggles within a step.
	task automatic send_word(input func_t f, input logic signed [VALUE_W-1:0] v);
		cmd_t    c;
		result_t r;
		c.func = f;
		c.push_value = v;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		apply_queue_op(c, r);
		expected_words.push_back(r);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Stops sending and waits until every owed word has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_field(input string fname, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	// Result checker: done marks a one-cycle word that must match the oldest one owed.
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (expected_words.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: word with none owed, expected nothing actual done=%b",
					$time, done);
			end else begin
				want = expected_words.pop_front();
				report_field("popped_value", want.popped_value, result.popped_value);
				report_field("status", want.status, result.status);
				report_field("entry_count", want.entry_count, result.entry_count);
				report_field("total_sum", want.total_sum, result.total_sum);
				report_field("largest_value", want.largest_value, result.largest_value);
				report_field("is_empty", want.is_empty, result.is_empty);
			end
		end
	end

	// Pop and reverse on an empty queue report empty; query is always ok.
	task automatic test_empty_ops();
		send_word(FUNC_QUERY, $urandom());
		send_word(FUNC_POP, $urandom());
		send_word(FUNC_REVERSE, $urandom());
	endtask

	// Both value extremes, then a reverse so they come out back to front.
	task automatic test_value_extremes();
		send_word(FUNC_PUSH, VAL_MAX);
		send_word(FUNC_PUSH, VAL_MIN);
		send_word(FUNC_REVERSE, $urandom());
		send_word(FUNC_POP, $urandom());
		send_word(FUNC_POP, $urandom());
	endtask

	// Fill with the most negative value (sum at its floor), then push once more:
	// that word is dropped and flagged full.
	task automatic test_full_queue();
		for (int unsigned i = 0; i < DEPTH; i++)
			send_word(FUNC_PUSH, VAL_MIN);
		send_word(FUNC_PUSH, VAL_MAX);
	endtask

	// Random words in bursts that lean toward push or pop, so the queue swings
	// between full and empty; some bursts use only extreme values.
	task automatic test_random_phase(input int unsigned n_words, input int unsigned pct);
		int unsigned               push_w;
		int unsigned               pop_w;
		int unsigned               roll;
		bit                        extremes_only;
		func_t                     f;
		logic signed [VALUE_W-1:0] v;
		push_w = 40;
		pop_w = 30;
		extremes_only = 1'b0;
		idle_pct = pct;
		for (int unsigned i = 0; i < n_words; i++) begin
			if (i % 20 == 0) begin
				case ($urandom_range(2))
					0: begin push_w = 70; pop_w = 15; end
					1: begin push_w = 15; pop_w = 70; end
					default: begin push_w = 40; pop_w = 35; end
				endcase
				extremes_only = ($urandom_range(3) == 0);
			end
			roll = $urandom_range(99);
			if (roll < push_w)
				f = FUNC_PUSH;
			else if (roll < push_w + pop_w)
				f = FUNC_POP;
			else if (roll < push_w + pop_w + (100 - push_w - pop_w) / 2)
				f = FUNC_REVERSE;
			else
				f = FUNC_QUERY;
			if (extremes_only || $urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: v = VAL_MAX;
					1: v = VAL_MIN;
					2: v = '0;
					default: v = -1;
				endcase
			end else begin
				v = $urandom();
			end
			send_word(f, v);
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		idle_pct = 0;
		mismatch_count = 0;
		ring_front = 0;
		ring_count = 0;
		ring_rev = 1'b0;
		ring_sum = '0;
		foreach (ring_vals[i])
			ring_vals[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ops();
		test_value_extremes();
		test_full_queue();
		// sender holds off here until every owed word is back
		wait_drained();

		test_random_phase(200, 0);
		test_random_phase(200, 81);
		test_random_phase(200, 34);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
rtl/core/fqsmr_pkg.sv
rtl/core/fqsmr_ram.sv
rtl/core/fqsmr_ctrl.sv
rtl/core/fifo_queue_sum_max_reverse.sv
rtl/core/fqsmr_checker.sv
bench/tb_fifo_queue_sum_max_reverse.sv
